>>> design/crcfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the CRC-checked float decoder.
// No dependencies.
`timescale 1ns / 1ps

package crcfd_pkg;

  localparam logic [7:0]  CRC_POLY  = 8'h31;
  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [7:0]  EXP_BIAS  = 8'd127;
  localparam logic [6:0]  HUNDRED   = 7'd100;
  localparam int          MANT_W    = 23;
  localparam int          VALUE_W   = 23;
  localparam int          CLAMP_W   = 16;
  localparam int          VCOUNT_W  = 3;

  // Configuration register indexes
  localparam logic REG_VALUE_COUNT = 1'b0;
  localparam logic REG_CLAMP_LIMIT = 1'b1;

  // Byte position within one reading: data, data, CRC, data, data, CRC
  typedef enum logic [5:0] {
    POS_D0 = 6'b000001,
    POS_D1 = 6'b000010,
    POS_C0 = 6'b000100,
    POS_D2 = 6'b001000,
    POS_D3 = 6'b010000,
    POS_C1 = 6'b100000
  } pos_e;

  typedef struct packed {
    logic [31:0] bits;
    logic [1:0]  channel;
    logic        crc_error;
    logic        last;
  } raw_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> design/crcfd_deframe.sv
// Byte deframer: group position, running CRC-8 check, reading index and error latch.
// Holds one raw reading request until the output stage takes it. Uses crcfd_pkg.
`timescale 1ns / 1ps

module crcfd_deframe #(
  parameter int MAX_READINGS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           start_req_i,
  input  logic [crcfd_pkg::VCOUNT_W-1:0] value_count_i,
  input  logic                           take_i,
  output logic                           res_vld_o,
  output crcfd_pkg::raw_t                res_o
);

  localparam int IdxW = ($clog2(MAX_READINGS) > 2) ? $clog2(MAX_READINGS) : 2;
  localparam int CntW = ($clog2(MAX_READINGS + 1) > 3) ? $clog2(MAX_READINGS + 1) : 3;

  crcfd_pkg::pos_e pos_q, pos_d, pos_cur;
  logic [15:0]     hold_q, hold_d;
  logic [15:0]     upper_q, upper_d;
  logic [7:0]      crc_q, crc_d;
  logic [IdxW-1:0] idx_q, idx_d, idx_cur;
  logic            ovf_q, ovf_d, ovf_cur;
  logic            err_q, err_d, err_cur;
  logic            vld_q, vld_d;
  crcfd_pkg::raw_t res_q, res_d;
  logic            produce;
  logic [CntW-1:0] eff_cnt;
  logic            last;

  always_comb begin
    if (value_count_i == '0 || CntW'(value_count_i) > CntW'(MAX_READINGS)) begin
      eff_cnt = CntW'(MAX_READINGS);
    end else begin
      eff_cnt = CntW'(value_count_i);
    end
  end

  assign pos_cur = start_req_i ? crcfd_pkg::POS_D0 : pos_q;
  assign idx_cur = start_req_i ? '0 : idx_q;
  assign ovf_cur = start_req_i ? 1'b0 : ovf_q;
  assign err_cur = start_req_i ? 1'b0 : err_q;
  assign last    = !ovf_cur && (CntW'(idx_cur) == eff_cnt - CntW'(1));

  always_comb begin
    pos_d   = pos_q;
    hold_d  = hold_q;
    upper_d = upper_q;
    crc_d   = crc_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    err_d   = err_q;
    produce = 1'b0;
    res_d   = res_q;
    if (accept_i) begin
      pos_d = pos_cur;
      idx_d = idx_cur;
      ovf_d = ovf_cur;
      err_d = err_cur;
      if (!err_cur) begin
        unique case (pos_cur)
          crcfd_pkg::POS_D0, crcfd_pkg::POS_D2: begin
            hold_d = {rx_byte_i, 8'h00};
            crc_d  = crcfd_pkg::crc8_update(crcfd_pkg::CRC_INIT, rx_byte_i);
            pos_d  = (pos_cur == crcfd_pkg::POS_D0) ? crcfd_pkg::POS_D1 : crcfd_pkg::POS_D3;
          end
          crcfd_pkg::POS_D1, crcfd_pkg::POS_D3: begin
            hold_d = {hold_q[15:8], rx_byte_i};
            crc_d  = crcfd_pkg::crc8_update(crc_q, rx_byte_i);
            pos_d  = (pos_cur == crcfd_pkg::POS_D1) ? crcfd_pkg::POS_C0 : crcfd_pkg::POS_C1;
          end
          crcfd_pkg::POS_C0, crcfd_pkg::POS_C1: begin
            res_d.channel = idx_cur[1:0];
            res_d.last    = last;
            if (crc_q != rx_byte_i) begin
              produce         = 1'b1;
              res_d.bits      = '0;
              res_d.crc_error = 1'b1;
              err_d           = 1'b1;
              pos_d           = crcfd_pkg::POS_D0;
            end else if (pos_cur == crcfd_pkg::POS_C0) begin
              upper_d = hold_q;
              pos_d   = crcfd_pkg::POS_D2;
            end else begin
              produce         = 1'b1;
              res_d.bits      = {upper_q, hold_q};
              res_d.crc_error = 1'b0;
              pos_d           = crcfd_pkg::POS_D0;
              if (last) begin
                idx_d = '0;
              end else begin
                idx_d = idx_cur + IdxW'(1);
                ovf_d = ovf_cur | (&idx_cur);
              end
            end
          end
          default: begin
            pos_d = crcfd_pkg::POS_D0;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (produce) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= crcfd_pkg::POS_D0;
      hold_q  <= '0;
      upper_q <= '0;
      crc_q   <= crcfd_pkg::CRC_INIT;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      err_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      hold_q  <= hold_d;
      upper_q <= upper_d;
      crc_q   <= crc_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
      err_q   <= err_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_vld_o = vld_q;
  assign res_o     = res_q;

`ifndef NO_ASSERTIONS
  a_err_sets_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce && res_d.crc_error |=> err_q)
    else $error("CRC error request did not set the error latch");

  a_latched_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && err_q && !start_req_i |=> !vld_q && $stable(pos_q))
    else $error("byte decoded while error latch set");

  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce && res_d.last |-> res_d.channel == 2'(eff_cnt - CntW'(1)))
    else $error("last flag on wrong channel");
`endif

endmodule

>>> design/crcfd_convert.sv
// Float-to-hundredths conversion: truncating fixed-point with saturation at limit*100.
// Pure combinational, sign bit ignored. Uses crcfd_pkg.
`timescale 1ns / 1ps

module crcfd_convert (
  input  logic [31:0]                       bits_i,
  input  logic [crcfd_pkg::CLAMP_W-1:0]     clamp_limit_i,
  output logic [crcfd_pkg::VALUE_W-1:0]     value_o
);

  logic [crcfd_pkg::MANT_W-1:0] mant;
  logic [7:0]                   bexp;
  logic [7:0]                   rs;
  logic [7:0]                   e;
  logic [30:0]                  lead_x100;
  logic [7:0]                   small_t;
  logic [4:0]                   shift;
  logic [15:0]                  ipart;
  logic [crcfd_pkg::MANT_W-1:0] frac_mask;
  logic [crcfd_pkg::MANT_W-1:0] frac;
  logic [29:0]                  frac_x100;
  logic [6:0]                   fpart;
  logic [crcfd_pkg::VALUE_W-1:0] sat;
  logic [crcfd_pkg::VALUE_W-1:0] ivalue;

  assign mant      = bits_i[22:0];
  assign bexp      = bits_i[30:23];
  assign rs        = crcfd_pkg::EXP_BIAS - bexp;
  assign e         = bexp - crcfd_pkg::EXP_BIAS;
  assign lead_x100 = 31'({1'b1, mant}) * 31'(crcfd_pkg::HUNDRED);
  assign small_t   = lead_x100[30:23] >> rs[2:0];
  assign shift     = 5'(crcfd_pkg::MANT_W) - {1'b0, e[3:0]};
  assign ipart     = (16'd1 << e[3:0]) + 16'(mant >> shift);
  assign frac_mask = (23'd1 << shift) - 23'd1;
  assign frac      = mant & frac_mask;
  assign frac_x100 = 30'(frac) * 30'(crcfd_pkg::HUNDRED);
  assign fpart     = 7'(frac_x100 >> shift);
  assign sat       = 23'(clamp_limit_i) * 23'(crcfd_pkg::HUNDRED);
  assign ivalue    = 23'(ipart) * 23'(crcfd_pkg::HUNDRED) + 23'(fpart);

  always_comb begin
    priority if (bexp == '0 && mant == '0) begin
      value_o = '0;
    end else if (bexp < crcfd_pkg::EXP_BIAS) begin
      value_o = (rs >= 8'd8) ? '0 : 23'(small_t);
    end else if (e >= 8'd16) begin
      value_o = sat;
    end else if (ipart >= clamp_limit_i) begin
      value_o = sat;
    end else begin
      value_o = ivalue;
    end
  end

endmodule

>>> design/crc_checked_float_reading_decoder_unit.sv
// Top level of the CRC-checked float reading decoder: config registers, output register.
// Instantiates crcfd_deframe and crcfd_convert; uses crcfd_pkg.
`timescale 1ns / 1ps

// Takes one response byte per clock while in_stall_o is low: groups of two data
// bytes and a CRC-8 byte (poly 0x31, init 0xFF), two good groups giving one
// big-endian float reading that leaves as hundredths, saturated at clamp_limit*100.
// start_req_i marks the first byte of a response. A CRC mismatch gives one result
// with crc_error_o set and then bytes are dropped until the next start. Sustained
// rate is one byte per cycle while in_stall_o is low; a result passes from its CRC
// byte through the deframer's request register and then the conversion and output
// register to the outputs. in_stall_o rises only when both the request register and
// the output register are full and the output is stalled.
module crc_checked_float_reading_decoder_unit #(
  parameter int MAX_READINGS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            start_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [crcfd_pkg::VALUE_W-1:0]   value_o,
  output logic [1:0]                      channel_o,
  output logic                            crc_error_o,
  output logic                            last_value_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [crcfd_pkg::CLAMP_W-1:0]   cfg_wdata_i
);

  logic [crcfd_pkg::VCOUNT_W-1:0] value_count_q;
  logic [crcfd_pkg::CLAMP_W-1:0]  clamp_limit_q;
  logic                           accept;
  logic                           res_vld;
  crcfd_pkg::raw_t                res;
  logic                           out_ready;
  logic                           take;
  logic [crcfd_pkg::VALUE_W-1:0]  conv_value;
  logic                           out_vld_q, out_vld_d;
  logic [crcfd_pkg::VALUE_W-1:0]  value_q;
  logic [1:0]                     channel_q;
  logic                           crc_error_q;
  logic                           last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_count_q <= crcfd_pkg::VCOUNT_W'(4);
      clamp_limit_q <= crcfd_pkg::CLAMP_W'(3000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        crcfd_pkg::REG_VALUE_COUNT: value_count_q <= cfg_wdata_i[crcfd_pkg::VCOUNT_W-1:0];
        crcfd_pkg::REG_CLAMP_LIMIT: clamp_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign take       = res_vld && out_ready;
  assign in_stall_o = res_vld && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  crcfd_deframe #(
    .MAX_READINGS(MAX_READINGS)
  ) u_deframe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .start_req_i  (start_req_i),
    .value_count_i(value_count_q),
    .take_i       (take),
    .res_vld_o    (res_vld),
    .res_o        (res)
  );

  crcfd_convert u_convert (
    .bits_i       (res.bits),
    .clamp_limit_i(clamp_limit_q),
    .value_o      (conv_value)
  );

  always_comb begin
    if (take) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      value_q     <= conv_value;
      channel_q   <= res.channel;
      crc_error_q <= res.crc_error;
      last_q      <= res.last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign value_o      = value_q;
  assign channel_o    = channel_q;
  assign crc_error_o  = crc_error_q;
  assign last_value_o = last_q;

`ifndef NO_ASSERTIONS
  a_stall_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> res_vld && out_vld_q)
    else $error("input stalled with free request slot");

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crc_error_o |-> value_o == '0)
    else $error("CRC error result carries a nonzero value");

  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_o)
    else $error("taken request not presented at output");
`endif

endmodule
